// File: rtl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg: shared constants and types for the ray/box slab intersection unit
// Fixed-point format, divider geometry, register indexes and pipeline types.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  // Q-format of all coordinates and distances
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 32;

  // bound - origin needs one extra bit
  localparam int DIFF_W    = Q_W + 1;
  // scaled numerator magnitude and the part above the quotient width
  localparam int NUM_W     = DIFF_W + FRAC_BITS;
  localparam int HI_W      = NUM_W - Q_W;

  // divider stages: abs stage, overflow/setup stage, one stage per quotient
  // bit, then the saturation stage
  localparam int DIV_LAT   = Q_W + 3;

  localparam int AXES      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = 2 * AXES * Q_W;
  localparam int OUT_W     = 2 * Q_W;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  // per-ray flags that ride alongside the dividers
  typedef struct packed {
    logic [AXES-1:0] zero;
    logic [AXES-1:0] neg;
    logic            outside;
  } side_t;

  typedef struct packed {
    logic                  hit;
    logic signed [Q_W-1:0] t_enter;
    logic signed [Q_W-1:0] t_exit;
  } result_t;

endpackage

// File: rtl/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div: pipelined saturating fixed-point divider
// Computes sat((num_diff << FRAC_BITS) / den), truncated toward zero, with a
// restoring subtract of one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbsi_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [rbsi_pkg::DIFF_W-1:0] num_diff,
  input  logic signed [rbsi_pkg::Q_W-1:0]    den,
  output logic signed [rbsi_pkg::Q_W-1:0]    quo
);
  import rbsi_pkg::*;

  // abs stage
  logic [DIFF_W-1:0] a_mag;
  logic [Q_W-1:0]    a_dm;
  logic              a_neg;

  logic [NUM_W-1:0]  num_full;
  logic [HI_W-1:0]   num_hi;

  // bit stages, index 0 is the setup stage
  logic [Q_W-1:0]    rem  [Q_W];
  logic [Q_W-1:0]    low  [Q_W];
  logic [Q_W-1:0]    quot [Q_W+1];
  logic [Q_W-1:0]    dm   [Q_W];
  logic [Q_W:0]      ovf;
  logic [Q_W:0]      neg;
  logic [Q_W+1:0]    trial [Q_W];

  logic [Q_W-1:0]    q_fin;

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag <= num_diff[DIFF_W-1] ? DIFF_W'(-num_diff) : DIFF_W'(num_diff);
      a_dm  <= den[Q_W-1] ? Q_W'(-den) : Q_W'(den);
      a_neg <= num_diff[DIFF_W-1] ^ den[Q_W-1];
    end
  end

  assign num_full = {a_mag, {FRAC_BITS{1'b0}}};
  assign num_hi   = num_full[NUM_W-1:Q_W];

  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      trial[k] = {1'b0, rem[k], low[k][Q_W-1]} - {2'b00, dm[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quotient overflows Q_W bits exactly when the high part reaches the divisor
      rem[0]  <= Q_W'(num_hi);
      low[0]  <= num_full[Q_W-1:0];
      quot[0] <= '0;
      dm[0]   <= a_dm;
      ovf[0]  <= Q_W'(num_hi) >= a_dm;
      neg[0]  <= a_neg;
      for (int k = 0; k < Q_W; k++) begin
        quot[k+1] <= {quot[k][Q_W-2:0], ~trial[k][Q_W+1]};
        ovf[k+1]  <= ovf[k];
        neg[k+1]  <= neg[k];
      end
      for (int k = 0; k < Q_W-1; k++) begin
        if (trial[k][Q_W+1]) begin
          rem[k+1] <= {rem[k][Q_W-2:0], low[k][Q_W-1]};
        end else begin
          rem[k+1] <= trial[k][Q_W-1:0];
        end
        low[k+1] <= {low[k][Q_W-2:0], 1'b0};
        dm[k+1]  <= dm[k];
      end
    end
  end

  assign q_fin = quot[Q_W];

  // sign and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf[Q_W]) begin
        quo <= neg[Q_W] ? Q_MIN : Q_MAX;
      end else if (neg[Q_W]) begin
        quo <= (q_fin[Q_W-1] && (|q_fin[Q_W-2:0])) ? Q_MIN : (~q_fin + 1'b1);
      end else begin
        quo <= q_fin[Q_W-1] ? Q_MAX : q_fin;
      end
    end
  end

endmodule

// File: rtl/ray_box_slab_intersection_unit.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_unit: ray against axis-aligned box, slab method
// Fully pipelined fixed-point test, one ray per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one ray per transaction: origin x/y/z, then direction
//   x/y/z, all signed Q16.16. m_axis returns one result per ray, in order:
//   t_enter and t_exit in tdata, the hit flag in tuser.
//   The box bounds sit in six registers written through the cfg channel
//   (cfg_ready is always high); write them only while no ray is in flight.
// Dividers: six, one per slab plane; each resolves one quotient bit per
//   stage and is 35 stages deep.
// Throughput: one ray per cycle for as long as m_axis_tready stays high.
// Stall: when the receiver holds off, the finished result waits in the
//   output register and one more result lands in a skid register; only then
//   does s_axis_tready drop and the whole pipeline freeze, losing nothing.
// Reset: rst clears the pipeline and the output, and sets all box bounds
//   to zero.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [rbsi_pkg::IN_W-1:0]           s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // t_enter, t_exit
  output logic [rbsi_pkg::OUT_W-1:0]          m_axis_tdata,
  // hit
  output logic [0:0]                          m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbsi_pkg::Q_W-1:0]            cfg_data
);
  import rbsi_pkg::*;

  logic signed [Q_W-1:0] box_min [AXES];
  logic signed [Q_W-1:0] box_max [AXES];

  logic                  en;

  logic signed [Q_W-1:0] in_org [AXES];
  logic signed [Q_W-1:0] in_dir [AXES];
  logic                  in_outside;

  // entry stage
  logic                     va;
  logic signed [DIFF_W-1:0] a_diff_lo [AXES];
  logic signed [DIFF_W-1:0] a_diff_hi [AXES];
  logic signed [Q_W-1:0]    a_dir     [AXES];
  side_t                    a_side;

  logic signed [Q_W-1:0]    q_lo [AXES];
  logic signed [Q_W-1:0]    q_hi [AXES];

  logic [DIV_LAT-1:0]       v_line;
  side_t                    side_line [DIV_LAT];
  side_t                    side_end;

  logic signed [Q_W-1:0]    lo [AXES];
  logic signed [Q_W-1:0]    hi [AXES];

  // reduction stages
  logic                     vc;
  logic signed [Q_W-1:0]    c_lo01, c_hi01, c_lo2, c_hi2;
  logic                     c_outside;
  logic                     vd;
  logic signed [Q_W-1:0]    d_enter, d_leave;
  logic                     d_outside;

  result_t                  ex_res;
  result_t                  out_res;
  result_t                  skid_res;
  logic                     out_valid;
  logic                     skid_valid;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        box_min[a] <= '0;
        box_max[a] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BOX_MIN_X: box_min[0] <= cfg_data;
        REG_BOX_MIN_Y: box_min[1] <= cfg_data;
        REG_BOX_MIN_Z: box_min[2] <= cfg_data;
        REG_BOX_MAX_X: box_max[0] <= cfg_data;
        REG_BOX_MAX_Y: box_max[1] <= cfg_data;
        REG_BOX_MAX_Z: box_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a result is parked in the skid register
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  always_comb begin
    in_outside = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      in_org[a] = s_axis_tdata[a*Q_W +: Q_W];
      in_dir[a] = s_axis_tdata[(a+AXES)*Q_W +: Q_W];
      // a flat axis misses when the origin lies outside that slab
      if (in_dir[a] == '0 && (in_org[a] < box_min[a] || in_org[a] > box_max[a])) begin
        in_outside = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        a_diff_lo[a]   <= DIFF_W'(box_min[a]) - DIFF_W'(in_org[a]);
        a_diff_hi[a]   <= DIFF_W'(box_max[a]) - DIFF_W'(in_org[a]);
        a_dir[a]       <= in_dir[a];
        a_side.zero[a] <= (in_dir[a] == '0);
        a_side.neg[a]  <= in_dir[a][Q_W-1];
      end
      a_side.outside <= in_outside;
    end
  end

  // one divider per slab plane
  for (genvar g = 0; g < AXES; g++) begin : g_axis
    rbsi_div u_div_lo (
      .clk      (clk),
      .en       (en),
      .num_diff (a_diff_lo[g]),
      .den      (a_dir[g]),
      .quo      (q_lo[g])
    );
    rbsi_div u_div_hi (
      .clk      (clk),
      .en       (en),
      .num_diff (a_diff_hi[g]),
      .den      (a_dir[g]),
      .quo      (q_hi[g])
    );
  end

  // flags travel beside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      v_line <= '0;
    end else if (en) begin
      v_line <= {v_line[DIV_LAT-2:0], va};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_line[0] <= a_side;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_line[k] <= side_line[k-1];
      end
    end
  end

  assign side_end = side_line[DIV_LAT-1];

  // order plane distances by direction sign, flat axes span everything
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      if (side_end.zero[a]) begin
        lo[a] = Q_MIN;
        hi[a] = Q_MAX;
      end else if (side_end.neg[a]) begin
        lo[a] = q_hi[a];
        hi[a] = q_lo[a];
      end else begin
        lo[a] = q_lo[a];
        hi[a] = q_hi[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (en) begin
      vc <= v_line[DIV_LAT-1];
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_lo01    <= (lo[1] > lo[0]) ? lo[1] : lo[0];
      c_hi01    <= (hi[1] < hi[0]) ? hi[1] : hi[0];
      c_lo2     <= lo[2];
      c_hi2     <= hi[2];
      c_outside <= side_end.outside;
      d_enter   <= (c_lo2 > c_lo01) ? c_lo2 : c_lo01;
      d_leave   <= (c_hi2 < c_hi01) ? c_hi2 : c_hi01;
      d_outside <= c_outside;
    end
  end

  assign ex_res.hit     = !d_outside && (d_enter < d_leave);
  assign ex_res.t_enter = d_enter;
  assign ex_res.t_exit  = d_leave;

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en) begin
      if (vd) begin
        if (!out_valid || m_axis_tready) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end else if (m_axis_tready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (vd && (!out_valid || m_axis_tready)) begin
        out_res <= ex_res;
      end
      if (vd && out_valid && !m_axis_tready) begin
        skid_res <= ex_res;
      end
    end else if (m_axis_tready) begin
      out_res <= skid_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.t_exit, out_res.t_enter};
  assign m_axis_tuser  = out_res.hit;

`ifndef SYNTH
  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_axis_tready) |=> !skid_valid)
    else $error("skid register not drained after a transaction");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_axis_tready))
    else $error("skid filled without a stalled output");

  a_exit_lands: assert property (@(posedge clk) disable iff (rst)
    (en && vd) |=> out_valid)
    else $error("result leaving the pipeline was lost");

  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.hit) |-> (out_res.t_enter < out_res.t_exit))
    else $error("hit flagged with entry not below exit");
`endif

endmodule

// File: tb/slab_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slab_result_checker: result predictor and comparator for the slab test unit
// Keeps its own copy of the six box bounds from the cfg channel. For each ray
// accepted on s_axis it works out the slab test result and queues it. Each
// result accepted on m_axis is checked field by field against the oldest
// queued result.
// ----------------------------------------------------------------------------
module slab_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [rbsi_pkg::IN_W-1:0]      s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // t_enter, t_exit
  input  logic [rbsi_pkg::OUT_W-1:0]     m_axis_tdata,
  // hit
  input  logic [0:0]                     m_axis_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbsi_pkg::Q_W-1:0]       cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import rbsi_pkg::*;

  longint  box_lo [AXES];
  longint  box_hi [AXES];
  result_t expected_results [$];
  int      errors = 0;

  // distance to one slab plane, truncated toward zero, clipped to Q16.16
  function automatic longint plane_t(input longint bound, input longint org,
                                     input longint dir);
    longint q;
    q = ((bound - org) * (longint'(1) <<< FRAC_BITS)) / dir;
    if (q > longint'(Q_MAX)) q = longint'(Q_MAX);
    if (q < longint'(Q_MIN)) q = longint'(Q_MIN);
    return q;
  endfunction

  function automatic result_t slab_result(input logic [IN_W-1:0] ray);
    longint  org, dir, lo, hi, tmp, enter, leave;
    logic    outside;
    result_t r;
    enter   = longint'(Q_MIN);
    leave   = longint'(Q_MAX);
    outside = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      org = $signed(ray[a*Q_W +: Q_W]);
      dir = $signed(ray[(a+AXES)*Q_W +: Q_W]);
      if (dir == 0) begin
        // parallel to the slab: all t, but a miss if the origin is outside it
        lo = longint'(Q_MIN);
        hi = longint'(Q_MAX);
        if (org < box_lo[a] || org > box_hi[a]) outside = 1'b1;
      end else begin
        lo = plane_t(box_lo[a], org, dir);
        hi = plane_t(box_hi[a], org, dir);
        if (dir < 0) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
      end
      if (lo > enter) enter = lo;
      if (hi < leave) leave = hi;
    end
    r.hit     = !outside && (enter < leave);
    r.t_enter = enter[Q_W-1:0];
    r.t_exit  = leave[Q_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want, got;
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        box_lo[a] = 0;
        box_hi[a] = 0;
      end
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BOX_MIN_X: box_lo[0] = $signed(cfg_data);
          REG_BOX_MIN_Y: box_lo[1] = $signed(cfg_data);
          REG_BOX_MIN_Z: box_lo[2] = $signed(cfg_data);
          REG_BOX_MAX_X: box_hi[0] = $signed(cfg_data);
          REG_BOX_MAX_Y: box_hi[1] = $signed(cfg_data);
          REG_BOX_MAX_Z: box_hi[2] = $signed(cfg_data);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(slab_result(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit     = m_axis_tuser[0];
        got.t_enter = m_axis_tdata[Q_W-1:0];
        got.t_exit  = m_axis_tdata[2*Q_W-1:Q_W];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got hit %b t_enter %h t_exit %h",
                   $time, got.hit, got.t_enter, got.t_exit);
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit) begin
            errors++;
            $display("%0t: hit mismatch, expected %b, got %b", $time, want.hit, got.hit);
          end
          if (got.t_enter !== want.t_enter) begin
            errors++;
            $display("%0t: t_enter mismatch, expected %h, got %h",
                     $time, want.t_enter, got.t_enter);
          end
          if (got.t_exit !== want.t_exit) begin
            errors++;
            $display("%0t: t_exit mismatch, expected %h, got %h",
                     $time, want.t_exit, got.t_exit);
          end
        end
      end
    end
    pending    <= expected_results.size();
    fail_count <= errors;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: ray/box slab intersection unit
// Streams rays against a series of boxes (reset, directed, full range,
// inverted, random, flat and corner boxes) with random gaps and stalls on
// both sides, one long receiver hold-off, and checking by a separate checker.
// ----------------------------------------------------------------------------
module testbench;
  import rbsi_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  localparam int ONE          = 1 << FRAC_BITS;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 3000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  logic [IN_W-1:0]      s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // t_enter, t_exit
  logic [OUT_W-1:0]     m_axis_tdata;
  // hit
  logic [0:0]           m_axis_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [Q_W-1:0]       cfg_data;

  int     fail_count;
  int     pending;
  bit     tx_steady;
  bit     rx_steady;
  bit     rx_hold_req;
  longint cur_lo [AXES];
  longint cur_hi [AXES];

  always #(CLK_PERIOD / 2) clk = ~clk;

  ray_box_slab_intersection_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  slab_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // mostly back to back, sometimes a short gap, rarely a long gap
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [IN_W-1:0] ray_of(
    input logic signed [Q_W-1:0] ox, input logic signed [Q_W-1:0] oy,
    input logic signed [Q_W-1:0] oz, input logic signed [Q_W-1:0] dx,
    input logic signed [Q_W-1:0] dy, input logic signed [Q_W-1:0] dz);
    return {dz, dy, dx, oz, oy, ox};
  endfunction

  // most rays are aimed through a point of the current box, the rest are wild
  function automatic logic [IN_W-1:0] random_ray();
    logic signed [Q_W-1:0] org [AXES];
    logic signed [Q_W-1:0] dir [AXES];
    longint                span, tgt, pos;
    bit                    aimed;
    aimed = $urandom_range(0, 9) < 6;
    for (int a = 0; a < AXES; a++) begin
      case ($urandom_range(0, 9))
        0:       dir[a] = '0;
        1, 2:    dir[a] = int'($urandom_range(0, 31)) - 16;
        3, 4, 5: dir[a] = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
        default: dir[a] = $urandom;
      endcase
      if (aimed) begin
        span = cur_hi[a] - cur_lo[a];
        if (span <= 0) tgt = cur_lo[a];
        else tgt = cur_lo[a] + longint'({$urandom, $urandom} % 64'(span + 1));
        pos = tgt - longint'(dir[a]) * $urandom_range(0, 12);
        if (pos > longint'(Q_MAX)) pos = longint'(Q_MAX);
        if (pos < longint'(Q_MIN)) pos = longint'(Q_MIN);
        org[a] = pos[Q_W-1:0];
      end else begin
        case ($urandom_range(0, 5))
          0:       org[a] = Q_MIN;
          1:       org[a] = Q_MAX;
          2, 3:    org[a] = int'($urandom_range(0, 64 * ONE)) - 32 * ONE;
          default: org[a] = $urandom;
        endcase
      end
    end
    return ray_of(org[0], org[1], org[2], dir[0], dir[1], dir[2]);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_box(
    input logic signed [Q_W-1:0] lx, input logic signed [Q_W-1:0] ly,
    input logic signed [Q_W-1:0] lz, input logic signed [Q_W-1:0] hx,
    input logic signed [Q_W-1:0] hy, input logic signed [Q_W-1:0] hz);
    write_reg(REG_BOX_MIN_X, lx);
    write_reg(REG_BOX_MIN_Y, ly);
    write_reg(REG_BOX_MIN_Z, lz);
    write_reg(REG_BOX_MAX_X, hx);
    write_reg(REG_BOX_MAX_Y, hy);
    write_reg(REG_BOX_MAX_Z, hz);
    cfg_valid <= 1'b0;
    cur_lo[0] = lx;
    cur_lo[1] = ly;
    cur_lo[2] = lz;
    cur_hi[0] = hx;
    cur_hi[1] = hy;
    cur_hi[2] = hz;
  endtask

  task automatic send_ray(input logic [IN_W-1:0] ray);
    int gap;
    s_axis_tdata  <= ray;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    gap = tx_steady ? 0 : idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering rays until every outstanding result is back
  task automatic drain_rays();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stalls, steady stretches, and a long hold-off on request
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else if (rx_steady) begin
        stall = 0;
      end else begin
        stall = idle_gap();
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // watchdog on cycles with no transaction on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[ray_box_slab_intersection_unit] ERROR");
    $finish;
  end

  initial begin
    logic signed [Q_W-1:0] lo [AXES];
    logic signed [Q_W-1:0] hi [AXES];
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_BOX_MIN_X;
    cfg_data      <= '0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    rx_hold_req = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      cur_lo[a] = 0;
      cur_hi[a] = 0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // box still at its reset value: a single point at the origin
    repeat (40) send_ray(random_ray());
    drain_rays();

    set_box(-ONE, -2 * ONE, -3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE);
    send_ray(ray_of(-2 * ONE, 0, 0, ONE, 0, 0));
    send_ray(ray_of(10 * ONE, ONE, ONE, -ONE, 0, 0));
    // all directions zero, inside, outside and on both bound corners
    send_ray(ray_of(0, 0, 0, 0, 0, 0));
    send_ray(ray_of(0, 9 * ONE, 0, 0, 0, 0));
    send_ray(ray_of(4 * ONE, 5 * ONE, 6 * ONE, 0, 0, 0));
    send_ray(ray_of(-ONE, -2 * ONE, -3 * ONE, 0, 0, 0));
    // smallest direction steps, where quotients saturate, then extreme origins and directions
    send_ray(ray_of(0, 0, 0, 1, 1, 1));
    send_ray(ray_of(0, 0, 0, -1, -1, -1));
    send_ray(ray_of(0, 0, 0, Q_MIN, Q_MAX, Q_MIN));
    send_ray(ray_of(Q_MIN, Q_MAX, Q_MIN, ONE, -ONE, ONE));
    send_ray(ray_of(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
    // pointing away: negative distances
    send_ray(ray_of(-2 * ONE, 0, 0, -ONE, 0, 0));
    // grazing an edge: entry equals exit
    send_ray(ray_of(-2 * ONE, 11 * ONE, 0, ONE, -ONE, 0));
    // parallel to y with the origin above the slab
    send_ray(ray_of(-2 * ONE, 20 * ONE, 0, ONE, 0, 0));
    send_ray(ray_of(-2 * ONE, -3 * ONE, -4 * ONE, ONE, ONE, ONE));
    // fractional quotients, truncated toward zero
    send_ray(ray_of(0, 0, 0, 3 * ONE, -7 * ONE, 11 * ONE));
    send_ray(ray_of(Q_MIN, 0, 0, Q_MAX, 0, 0));
    send_ray(ray_of(-1, -1, -1, -1, -1, -1));
    repeat (200) send_ray(random_ray());
    drain_rays();

    // full-range box; receiver holds off while rays keep coming
    set_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    tx_steady   = 1'b1;
    rx_hold_req = 1'b1;
    repeat (120) send_ray(random_ray());
    tx_steady = 1'b0;
    repeat (80) send_ray(random_ray());
    drain_rays();

    // inverted box
    set_box(3 * ONE, 3 * ONE, 3 * ONE, -3 * ONE, -3 * ONE, -3 * ONE);
    repeat (150) send_ray(random_ray());
    drain_rays();

    // random boxes, the first ones with no idling on either side
    for (int n = 0; n < 6; n++) begin
      tx_steady = (n < 3);
      rx_steady = (n < 3);
      for (int a = 0; a < AXES; a++) begin
        lo[a] = int'($urandom_range(0, 40 * ONE)) - 20 * ONE;
        hi[a] = lo[a] + int'($urandom_range(0, 10 * ONE));
      end
      set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
      repeat (80) send_ray(random_ray());
      drain_rays();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    // flat box, min equal to max
    for (int a = 0; a < AXES; a++) lo[a] = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
    set_box(lo[0], lo[1], lo[2], lo[0], lo[1], lo[2]);
    repeat (150) send_ray(random_ray());
    drain_rays();

    // box squeezed into the far corner of the range
    set_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    repeat (60) send_ray(random_ray());
    drain_rays();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ray_box_slab_intersection_unit] OK");
    end else begin
      $display("[ray_box_slab_intersection_unit] ERROR");
    end
    $finish;
  end

endmodule
